// ===== src/b64e_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, constants and the alphabet lookup for the base64 encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

	localparam int CHAR_W    = 7;
	localparam int SEXTET_W  = 6;
	localparam int CHARS_MAX = 4;
	localparam int SLOT_W    = 2;

	localparam logic [CHAR_W-1:0] PAD_CHAR   = 7'h3D; // '='
	localparam logic [CHAR_W-1:0] PLUS_CHAR  = 7'h2B; // '+'
	localparam logic [CHAR_W-1:0] SLASH_CHAR = 7'h2F; // '/'

	// position within the current three-byte group
	typedef enum logic [2:0] {
		PH_0 = 3'b001,
		PH_1 = 3'b010,
		PH_2 = 3'b100
	} b64e_phase_t;

	// one classified input beat: up to four characters
	typedef struct packed {
		logic [CHARS_MAX-1:0][CHAR_W-1:0] chars;
		logic [SLOT_W-1:0]                last_idx;
		logic                             fin;
	} b64e_job_t;

	typedef struct packed {
		b64e_phase_t phase;
	} b64e_front_stat_t;

	function automatic logic [CHAR_W-1:0] b64_sym(input logic [SEXTET_W-1:0] v);
		logic [CHAR_W-1:0] w;
		logic [CHAR_W-1:0] r;
		w = CHAR_W'(v);
		if (v < 6'd26)
			r = w + 7'd65;      // 'A'..'Z'
		else if (v < 6'd52)
			r = w + 7'd71;      // 'a'..'z'
		else if (v < 6'd62)
			r = w - 7'd4;       // '0'..'9'
		else if (v == 6'd62)
			r = PLUS_CHAR;
		else
			r = SLASH_CHAR;
		return r;
	endfunction

endpackage

// ===== src/b64e_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_front
// Accepts raw bytes, tracks group phase and leftover bits, and builds one
// job of one to four characters per byte.
// ----------------------------------------------------------------------------
module b64e_front
	import b64e_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  logic [7:0]       data_byte,
	input  logic             final_byte,
	output b64e_job_t        job,
	output b64e_front_stat_t stat
);

	b64e_phase_t phase_q, phase_d;
	logic [3:0]  left_q, left_d;

	always_comb begin
		job      = '0;
		phase_d  = phase_q;
		left_d   = left_q;
		case (phase_q)
			PH_1: begin
				job.chars[0] = b64_sym({left_q[1:0], data_byte[7:4]});
				if (final_byte) begin
					job.chars[1] = b64_sym({data_byte[3:0], 2'b00});
					job.chars[2] = PAD_CHAR;
					job.last_idx = 2'd2;
					job.fin      = 1'b1;
					phase_d      = PH_0;
					left_d       = '0;
				end else begin
					job.last_idx = 2'd0;
					phase_d      = PH_2;
					left_d       = data_byte[3:0];
				end
			end
			PH_2: begin
				job.chars[0] = b64_sym({left_q, data_byte[7:6]});
				job.chars[1] = b64_sym(data_byte[5:0]);
				job.last_idx = 2'd1;
				job.fin      = final_byte;
				phase_d      = PH_0;
				left_d       = '0;
			end
			default: begin
				// start of group; also recovers from an illegal phase
				job.chars[0] = b64_sym(data_byte[7:2]);
				if (final_byte) begin
					job.chars[1] = b64_sym({data_byte[1:0], 4'b0000});
					job.chars[2] = PAD_CHAR;
					job.chars[3] = PAD_CHAR;
					job.last_idx = 2'd3;
					job.fin      = 1'b1;
					phase_d      = PH_0;
					left_d       = '0;
				end else begin
					job.last_idx = 2'd0;
					phase_d      = PH_1;
					left_d       = {2'b00, data_byte[1:0]};
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_0;
			left_q  <= '0;
		end else if (take) begin
			phase_q <= phase_d;
			left_q  <= left_d;
		end
	end

	assign stat.phase = phase_q;

endmodule

// ===== src/b64e_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_queue
// Small register FIFO of jobs between the front and the back.
// ----------------------------------------------------------------------------
module b64e_queue
	import b64e_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr,
	input  b64e_job_t wr_data,
	input  logic      rd,
	output b64e_job_t rd_data,
	output logic      full,
	output logic      empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	b64e_job_t         mem_q [DEPTH];
	logic [PW-1:0]     wptr_q, rptr_q;
	logic [CW-1:0]     cnt_q;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign rd_data = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr)
			mem_q[wptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr)
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			if (rd)
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			if (wr && !rd)
				cnt_q <= cnt_q + 1'b1;
			else if (rd && !wr)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ===== src/b64e_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_back
// Takes jobs from the queue and emits their characters through an output
// register, one per cycle while the receiver pops.
// ----------------------------------------------------------------------------
module b64e_back
	import b64e_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  b64e_job_t         q_data,
	output logic              q_rd,
	input  logic              pop,
	output logic              empty,
	output logic [CHAR_W-1:0] code_char,
	output logic              final_char
);

	b64e_job_t         job_q;
	logic              job_vld_q;
	logic [SLOT_W-1:0] idx_q;
	logic              ovld_q;
	logic [CHAR_W-1:0] char_q;
	logic              fin_q;

	logic adv, at_last, load;

	assign adv     = !ovld_q || pop;
	assign at_last = (idx_q == job_q.last_idx);
	// fetch a new job when idle or when the last char of this one leaves
	assign load    = !job_vld_q || (adv && at_last);
	assign q_rd    = load && !q_empty;

	always_ff @(posedge clk) begin
		if (q_rd)
			job_q <= q_data;
		if (adv && job_vld_q) begin
			char_q <= job_q.chars[idx_q];
			fin_q  <= job_q.fin && at_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_vld_q <= 1'b0;
			idx_q     <= '0;
			ovld_q    <= 1'b0;
		end else begin
			if (adv)
				ovld_q <= job_vld_q;
			if (load) begin
				job_vld_q <= !q_empty;
				idx_q     <= '0;
			end else if (adv) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	assign empty      = !ovld_q;
	assign code_char  = char_q;
	assign final_char = fin_q;

endmodule

// ===== src/base64_stream_encoder.sv =====
`timescale 1ns / 1ps
// Path: queue, then job register, then output register for a byte's first character.
// Throughput: one byte per cycle at the input while not full; one character per cycle
// at the output while popped; a byte yields 1 to 4 characters (4/3 on average mid-message).
// The job queue (QUEUE_DEPTH entries) absorbs the difference between the two rates.
// Reset: arst_n clears group phase, leftover bits, queue and output register at once.
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Streaming base64 encoder, standard alphabet, with '=' padding on the last byte.
// ----------------------------------------------------------------------------
module base64_stream_encoder
	import b64e_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [7:0]        data_byte,
	input  logic              final_byte,
	output logic              empty,
	input  logic              pop,
	output logic [CHAR_W-1:0] code_char,
	output logic              final_char
);

	b64e_job_t        f_job, q_data;
	b64e_front_stat_t f_stat;
	logic             q_wr, q_rd, q_full, q_empty;

	assign full = q_full;
	assign q_wr = push && !q_full;

	b64e_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (q_wr),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.job        (f_job),
		.stat       (f_stat)
	);

	b64e_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_wr),
		.wr_data (f_job),
		.rd      (q_rd),
		.rd_data (q_data),
		.full    (q_full),
		.empty   (q_empty)
	);

	b64e_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_data     (q_data),
		.q_rd       (q_rd),
		.pop        (pop),
		.empty      (empty),
		.code_char  (code_char),
		.final_char (final_char)
	);

`ifndef SYNTHESIS
	// a final beat always returns the group to its start
	a_final_resets_phase: assert property (@(posedge clk) disable iff (!arst_n)
		q_wr && final_byte |=> f_stat.phase == PH_0)
		else $error("group phase not cleared after final byte");

	a_rd_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_rd |-> !q_empty)
		else $error("job queue read while empty");

	a_wr_fills: assert property (@(posedge clk) disable iff (!arst_n)
		q_wr && !q_rd |=> !q_empty)
		else $error("job queue lost a written job");
`endif

endmodule

// ===== bench/base64_stream_encoder_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_encoder_check
// Watches both stream ports of the encoder, predicts the character stream from
// the accepted input beats and compares every popped character in order.
// ----------------------------------------------------------------------------
module base64_stream_encoder_check
	import b64e_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic              full,
	input  logic [7:0]        data_byte,
	input  logic              final_byte,
	input  logic              empty,
	input  logic              pop,
	input  logic [CHAR_W-1:0] code_char,
	input  logic              final_char,
	output int                fail_count,
	output int                pending
);

	localparam logic [64*8-1:0] B64_SYMBOLS =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} b64_char_t;

	b64_char_t  char_q[$];
	logic [1:0] grp_phase;
	logic [3:0] carry_bits;

	// first character of the literal sits in the top byte
	function automatic logic [CHAR_W-1:0] sextet_char(input logic [5:0] v);
		return B64_SYMBOLS[8*(63 - int'(v)) +: CHAR_W];
	endfunction

	task automatic add_char(input logic [CHAR_W-1:0] ch, input logic last);
		char_q.push_back('{ch: ch, last: last});
	endtask

	task automatic encode_byte(input logic [7:0] b, input logic fin);
		case (grp_phase)
			2'd1: begin
				add_char(sextet_char({carry_bits[1:0], b[7:4]}), 1'b0);
				if (fin) begin
					add_char(sextet_char({b[3:0], 2'b00}), 1'b0);
					add_char(PAD_CHAR, 1'b1);
					grp_phase  = 2'd0;
					carry_bits = 4'd0;
				end else begin
					carry_bits = b[3:0];
					grp_phase  = 2'd2;
				end
			end
			2'd2: begin
				add_char(sextet_char({carry_bits, b[7:6]}), 1'b0);
				add_char(sextet_char(b[5:0]), fin);
				grp_phase  = 2'd0;
				carry_bits = 4'd0;
			end
			// phase 3 never comes out of reset; treat it as a group start
			default: begin
				add_char(sextet_char(b[7:2]), 1'b0);
				if (fin) begin
					add_char(sextet_char({b[1:0], 4'b0000}), 1'b0);
					add_char(PAD_CHAR, 1'b0);
					add_char(PAD_CHAR, 1'b1);
					grp_phase  = 2'd0;
					carry_bits = 4'd0;
				end else begin
					carry_bits = {2'b00, b[1:0]};
					grp_phase  = 2'd1;
				end
			end
		endcase
	endtask

	task automatic log_mismatch(input string what, input b64_char_t want);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t: %s: expected char %h last %b, got char %h last %b",
				$time, what, want.ch, want.last, code_char, final_char);
	endtask

	always @(posedge clk or negedge arst_n) begin
		b64_char_t want;
		if (!arst_n) begin
			grp_phase  = 2'd0;
			carry_bits = 4'd0;
			char_q.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			// pop side first, a beat can never come out on the edge it goes in
			if (pop && !empty) begin
				if (char_q.size() == 0) begin
					log_mismatch("unexpected character", '0);
				end else begin
					want = char_q.pop_front();
					if (code_char !== want.ch || final_char !== want.last)
						log_mismatch("character mismatch", want);
				end
			end
			if (push && !full)
				encode_byte(data_byte, final_byte);
			pending = char_q.size();
		end
	end

endmodule

// ===== bench/base64_stream_encoder_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_encoder_test
// Drives byte messages into the encoder under several idle/stall mixes,
// including a long output hold-off, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module base64_stream_encoder_test;
	import b64e_pkg::*;

	localparam int HOLD_CYCLES  = 80;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int PHASE_ITEMS  = 28;
	localparam int DRAIN_CYCLES = 8;

	logic              clk        = 1'b0;
	logic              arst_n     = 1'b0;
	logic              push       = 1'b0;
	logic [7:0]        data_byte  = 8'h00;
	logic              final_byte = 1'b0;
	logic              pop        = 1'b0;
	logic              full;
	logic              empty;
	logic [CHAR_W-1:0] code_char;
	logic              final_char;

	int fail_count;
	int pending_chars;
	int idle_pct  = 0;
	int stall_pct = 0;
	int cycles    = 0;
	int held      = 0;
	bit hold_go   = 1'b0;
	bit hold_done = 1'b0;

	base64_stream_encoder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.empty      (empty),
		.pop        (pop),
		.code_char  (code_char),
		.final_char (final_char)
	);

	base64_stream_encoder_check checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.empty      (empty),
		.pop        (pop),
		.code_char  (code_char),
		.final_char (final_char),
		.fail_count (fail_count),
		.pending    (pending_chars)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// receiver: random stalls, or a long hold-off while hold_go is up
	always @(posedge clk) begin
		if (hold_go && !hold_done) begin
			pop <= 1'b0;
			held++;
			if (held >= HOLD_CYCLES)
				hold_done = 1'b1;
		end else begin
			pop <= ($urandom_range(99) >= stall_pct);
			if (!hold_go) begin
				hold_done = 1'b0;
				held      = 0;
			end
		end
	end

	// one input beat; returns at the edge that accepted it
	task automatic send_byte(input logic [7:0] b, input logic fin);
		bit took;
		while ($urandom_range(99) < idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push       <= 1'b1;
		data_byte  <= b;
		final_byte <= fin;
		do begin
			@(negedge clk);
			took = !full;
			@(posedge clk);
		end while (!took);
	endtask

	task automatic send_message(input int len);
		int r;
		logic [7:0] b;
		for (int i = 0; i < len; i++) begin
			r = $urandom_range(15);
			if (r == 0)
				b = 8'h00;
			else if (r == 1)
				b = 8'hFF;
			else
				b = 8'($urandom_range(255));
			send_byte(b, i == len - 1);
		end
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		@(posedge clk);
		while (pending_chars != 0)
			@(posedge clk);
	endtask

	initial begin
		// {final, byte}: one, two and three byte groups closing the message,
		// all-zero and all-one bytes, and sextets hitting '+' and '/'
		logic [8:0] directed[18] = '{
			9'h100, 9'h1FF,
			9'h0FB, 9'h1FF,
			9'h000, 9'h000, 9'h100,
			9'h0FF, 9'h0FF, 9'h0FF, 9'h1FF,
			9'h012, 9'h034, 9'h056, 9'h078, 9'h19A,
			9'h055, 9'h1AA
		};
		int sent;
		int len;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_byte(directed[i][7:0], directed[i][8]);
		wait_drained();

		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 73; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 73; end
				default: begin idle_pct = 37; stall_pct = 37; end
			endcase
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				len = ($urandom_range(9) == 0) ? $urandom_range(30, 10) : $urandom_range(6, 1);
				send_message(len);
				sent += len;
			end
			wait_drained();
		end

		// output held off long enough for the job queue to back up into full
		idle_pct  = 0;
		stall_pct = 0;
		hold_go   = 1'b1;
		send_message(16);
		while (!hold_done)
			@(posedge clk);
		hold_go = 1'b0;
		wait_drained();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_chars == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== files.f =====
src/b64e_pkg.sv
src/b64e_front.sv
src/b64e_queue.sv
src/b64e_back.sv
src/base64_stream_encoder.sv
bench/base64_stream_encoder_check.sv
bench/base64_stream_encoder_test.sv
